>>> design/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the token scanner
// request structs, scan modes, token and error codes, keyword table and the
// character class helpers
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int KEYWORD_BUFFER_CHARS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF          = 4;

    // longest keyword in the table
    localparam int KW_MAX_LEN = 7;
    localparam int KW_COUNT   = 16;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } char_req_t;

    typedef struct packed {
        logic        has_token;
        logic [5:0]  token_kind;
        logic [30:0] token_value;
        logic [15:0] token_length;
        logic [2:0]  error_code;
        logic        last_result;
    } tok_req_t;

    // everything one character produces, at most two requests
    typedef struct packed {
        logic     second_valid;
        tok_req_t first;
        tok_req_t second;
    } step_t;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_LT,
        MODE_GT,
        MODE_EQ,
        MODE_BANG,
        MODE_CHAR,
        MODE_STR
    } scan_mode_t;

    // token kinds
    localparam logic [5:0] K_PLUS      = 6'd16;
    localparam logic [5:0] K_MINUS     = 6'd17;
    localparam logic [5:0] K_TIMES     = 6'd18;
    localparam logic [5:0] K_DIVID     = 6'd19;
    localparam logic [5:0] K_EQL       = 6'd20;
    localparam logic [5:0] K_NEQ       = 6'd21;
    localparam logic [5:0] K_GTR       = 6'd22;
    localparam logic [5:0] K_LSS       = 6'd23;
    localparam logic [5:0] K_LEQ       = 6'd24;
    localparam logic [5:0] K_GEQ       = 6'd25;
    localparam logic [5:0] K_LPARENT   = 6'd26;
    localparam logic [5:0] K_RPARENT   = 6'd27;
    localparam logic [5:0] K_LBRACK    = 6'd28;
    localparam logic [5:0] K_RBRACK    = 6'd29;
    localparam logic [5:0] K_LBRACE    = 6'd30;
    localparam logic [5:0] K_RBRACE    = 6'd31;
    localparam logic [5:0] K_COMMA     = 6'd32;
    localparam logic [5:0] K_BECOMES   = 6'd33;
    localparam logic [5:0] K_IDENT     = 6'd34;
    localparam logic [5:0] K_NUMBER    = 6'd35;
    localparam logic [5:0] K_UNSG      = 6'd36;
    localparam logic [5:0] K_CHCON     = 6'd39;
    localparam logic [5:0] K_STRCON    = 6'd40;
    localparam logic [5:0] K_SEMICOLON = 6'd41;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BANG     = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd2;
    localparam logic [2:0] ERR_LITERAL  = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LBRC   = 8'h7B;
    localparam logic [7:0] CH_RBRC   = 8'h7D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    // keyword text, right aligned: char j sits at byte (len - 1 - j)
    localparam logic [8*KW_MAX_LEN-1:0] KW_STR [KW_COUNT] = '{
        "for", "while", "do", "if", "else", "switch", "case", "default",
        "int", "char", "const", "printf", "scanf", "void", "main", "return"
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd2, 3'd2, 3'd4, 3'd6, 3'd4, 3'd7,
        3'd3, 3'd4, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd6
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL;
    endfunction

    function automatic logic is_char_ok(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic is_str_ok(input logic [7:0] c);
        return c == CH_SPACE || c == CH_BANG || (c >= CH_HASH && c <= CH_TILDE);
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_LPAR || c == CH_RPAR || c == CH_LBRK || c == CH_RBRK ||
               c == CH_LBRC || c == CH_RBRC || c == CH_COMMA || c == CH_SEMI;
    endfunction

    function automatic logic [5:0] sym_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            CH_PLUS:  k = K_PLUS;
            CH_MINUS: k = K_MINUS;
            CH_STAR:  k = K_TIMES;
            CH_SLASH: k = K_DIVID;
            CH_LPAR:  k = K_LPARENT;
            CH_RPAR:  k = K_RPARENT;
            CH_LBRK:  k = K_LBRACK;
            CH_RBRK:  k = K_RBRACK;
            CH_LBRC:  k = K_LBRACE;
            CH_RBRC:  k = K_RBRACE;
            CH_COMMA: k = K_COMMA;
            CH_SEMI:  k = K_SEMICOLON;
            default:  k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

>>> design/c_subset_token_scanner.sv
// ----------------------------------------------------------------------------
// c_subset_token_scanner: character-at-a-time scanner for a small C subset
// takes one source byte per request and reports completed tokens
// ----------------------------------------------------------------------------
// usage
//   char channel: char_valid/char_stall/char_req, one byte or an end mark
//   per request; tok channel: tok_valid/tok_stall/tok_req, one token or
//   error report per request, last_result marks the final one of a byte
// throughput
//   one character per cycle while char_stall is low; a byte that closes
//   one token and starts another gives two requests, which the output
//   stage sends one after the other
// output path
//   an accepted character reaches its first output request through the
//   queue entry, then the output stage register
// reset
//   scanner goes idle with no pending token, queue and output stage empty
// stall
//   when tok_stall holds, requests pile up in the queue; once it is full
//   char_stall rises until the output stage drains an entry
// ----------------------------------------------------------------------------
module c_subset_token_scanner #(
    parameter int KEYWORD_BUFFER_CHARS = cst_pkg::KEYWORD_BUFFER_CHARS_DEF,
    parameter int QUEUE_DEPTH          = cst_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  cst_pkg::char_req_t char_req,
    output logic              tok_valid,
    input  logic              tok_stall,
    output cst_pkg::tok_req_t tok_req
);
    import cst_pkg::*;

    logic  accept;
    logic  emit;
    step_t step;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    step_t q_data;

    // queue full is the only back pressure toward the source
    assign char_stall = q_full;
    assign accept     = char_valid && !q_full;

    // front: scanner state and token classification
    cst_front #(
        .KEYWORD_BUFFER_CHARS(KEYWORD_BUFFER_CHARS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .char_req (char_req),
        .emit     (emit),
        .step     (step)
    );

    // decoupling queue, one entry per character that gives output
    cst_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit),
        .push_data  (step),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

    // back: serializes each record into output requests
    cst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_req   (tok_req)
    );

endmodule

>>> design/cst_front.sv
// ----------------------------------------------------------------------------
// cst_front: character scanner
// holds the pending token and turns each accepted character into a step
// record of zero, one or two token requests
// ----------------------------------------------------------------------------
module cst_front #(
    parameter int KEYWORD_BUFFER_CHARS = cst_pkg::KEYWORD_BUFFER_CHARS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  cst_pkg::char_req_t char_req,
    output logic              emit,
    output cst_pkg::step_t    step
);
    import cst_pkg::*;

    localparam int BUF_IW = $clog2(KEYWORD_BUFFER_CHARS);

    typedef struct packed {
        logic use_start;
        logic use_flush;
        logic op_eq;
        logic lit_bad;
        logic grow_word;
        logic grow_num;
        logic grow_char;
        logic grow_str;
    } act_t;

    scan_mode_t  mode_reg, mode_next;
    logic [7:0]  buf_reg [KEYWORD_BUFFER_CHARS];
    logic        too_long_reg, too_long_next;
    logic [30:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  first_reg, first_next;

    logic              buf_we;
    logic [BUF_IW-1:0] buf_wa;

    logic [7:0]  ch;
    logic        eoi;
    logic [15:0] len_inc;
    logic [34:0] acc_prod;
    logic [5:0]  word_kind;
    act_t        act;

    logic       st_emit;
    tok_req_t   st_res;
    scan_mode_t st_mode;
    logic       fl_emit;
    tok_req_t   fl_res;

    assign ch  = char_req.char_code;
    assign eoi = char_req.end_of_input;

    assign len_inc  = (len_reg == LEN_MAX) ? len_reg : len_reg + 16'd1;
    assign acc_prod = 35'({acc_reg, 3'b000}) + 35'({acc_reg, 1'b0}) + 35'(ch[3:0]);

    // keyword lookup over the buffered word
    always_comb
    begin
        logic m;
        word_kind = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            m = (len_reg == 16'(KW_LEN[i]));
            for (int j = 0; j < KW_MAX_LEN; j++)
            begin
                if (j < int'(KW_LEN[i]))
                    m = m && (buf_reg[j] == KW_STR[i][8*(int'(KW_LEN[i])-1-j) +: 8]);
            end
            if (m && !too_long_reg)
                word_kind = 6'(i);
        end
    end

    // what a character does when scanned between tokens
    always_comb
    begin
        st_emit = 1'b0;
        st_res  = '0;
        st_mode = MODE_IDLE;
        priority if (is_space(ch))
            st_mode = MODE_IDLE;
        else if (is_alpha(ch))
            st_mode = MODE_WORD;
        else if (ch == CH_ZERO)
        begin
            st_emit               = 1'b1;
            st_res.has_token      = 1'b1;
            st_res.token_kind     = K_NUMBER;
            st_res.token_length   = 16'd1;
        end
        else if (is_digit(ch))
            st_mode = MODE_NUM;
        else if (ch == CH_LT)
            st_mode = MODE_LT;
        else if (ch == CH_GT)
            st_mode = MODE_GT;
        else if (ch == CH_EQ)
            st_mode = MODE_EQ;
        else if (ch == CH_BANG)
            st_mode = MODE_BANG;
        else if (ch == CH_QUOTE)
            st_mode = MODE_CHAR;
        else if (ch == CH_DQUOTE)
            st_mode = MODE_STR;
        else if (is_symbol(ch))
        begin
            st_emit             = 1'b1;
            st_res.has_token    = 1'b1;
            st_res.token_kind   = sym_kind(ch);
            st_res.token_length = 16'd1;
        end
        else
        begin
            st_emit           = 1'b1;
            st_res.error_code = ERR_UNKNOWN;
        end
    end

    // report of the pending token
    always_comb
    begin
        fl_emit = 1'b1;
        fl_res  = '0;
        fl_res.has_token = 1'b1;
        unique case (mode_reg)
            MODE_WORD:
            begin
                fl_res.token_kind   = word_kind;
                fl_res.token_length = len_reg;
            end
            MODE_NUM:
            begin
                fl_res.token_kind   = K_UNSG;
                fl_res.token_value  = acc_reg;
                fl_res.token_length = len_reg;
                fl_res.error_code   = ovf_reg ? ERR_OVERFLOW : ERR_NONE;
            end
            MODE_LT:
            begin
                fl_res.token_kind   = K_LSS;
                fl_res.token_length = 16'd1;
            end
            MODE_GT:
            begin
                fl_res.token_kind   = K_GTR;
                fl_res.token_length = 16'd1;
            end
            MODE_EQ:
            begin
                fl_res.token_kind   = K_BECOMES;
                fl_res.token_length = 16'd1;
            end
            MODE_BANG:
            begin
                fl_res.has_token  = 1'b0;
                fl_res.error_code = ERR_BANG;
            end
            MODE_CHAR:
            begin
                fl_res.token_kind   = K_CHCON;
                fl_res.token_value  = 31'(first_reg);
                fl_res.token_length = len_reg;
            end
            MODE_STR:
            begin
                fl_res.token_kind   = K_STRCON;
                fl_res.token_length = len_reg;
            end
            default:
            begin
                fl_emit          = 1'b0;
                fl_res.has_token = 1'b0;
            end
        endcase
    end

    // classify the character against the current mode
    always_comb
    begin
        act = '0;
        if (eoi)
            act.use_flush = 1'b1;
        else
        begin
            unique case (mode_reg)
                MODE_WORD:
                begin
                    act.grow_word = is_alpha(ch) || is_digit(ch);
                    act.use_flush = !act.grow_word;
                    act.use_start = !act.grow_word;
                end
                MODE_NUM:
                begin
                    act.grow_num  = is_digit(ch);
                    act.use_flush = !act.grow_num;
                    act.use_start = !act.grow_num;
                end
                MODE_LT, MODE_GT, MODE_EQ, MODE_BANG:
                begin
                    act.op_eq     = (ch == CH_EQ);
                    act.use_flush = !act.op_eq;
                    act.use_start = !act.op_eq;
                end
                MODE_CHAR:
                begin
                    act.use_flush = (ch == CH_QUOTE);
                    act.grow_char = !act.use_flush && is_char_ok(ch);
                    act.lit_bad   = !act.use_flush && !is_char_ok(ch);
                end
                MODE_STR:
                begin
                    act.use_flush = (ch == CH_DQUOTE);
                    act.grow_str  = !act.use_flush && is_str_ok(ch);
                    act.lit_bad   = !act.use_flush && !is_str_ok(ch);
                end
                default:
                    act.use_start = 1'b1;
            endcase
        end
    end

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            priority if (act.use_start)
                mode_next = st_mode;
            else if (act.use_flush || act.op_eq)
                mode_next = MODE_IDLE;
            else
                mode_next = mode_reg;
        end
    end

    // token state updates
    always_comb
    begin
        too_long_next = too_long_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        len_next      = len_reg;
        first_next    = first_reg;
        buf_we        = 1'b0;
        buf_wa        = len_reg[BUF_IW-1:0];
        if (accept)
        begin
            priority if (act.use_start)
            begin
                len_next = 16'd0;
                unique case (st_mode)
                    MODE_WORD:
                    begin
                        too_long_next = 1'b0;
                        buf_we        = 1'b1;
                        buf_wa        = '0;
                        len_next      = 16'd1;
                    end
                    MODE_NUM:
                    begin
                        acc_next = 31'(ch[3:0]);
                        ovf_next = 1'b0;
                        len_next = 16'd1;
                    end
                    MODE_CHAR:
                        first_next = '0;
                    default:
                        len_next = 16'd0;
                endcase
            end
            else if (act.grow_word)
            begin
                if (len_reg < 16'(KEYWORD_BUFFER_CHARS))
                    buf_we = 1'b1;
                else
                    too_long_next = 1'b1;
                len_next = len_inc;
            end
            else if (act.grow_num)
            begin
                if (acc_prod[34:31] != 4'd0)
                begin
                    acc_next = VAL_MAX;
                    ovf_next = 1'b1;
                end
                else
                    acc_next = acc_prod[30:0];
                len_next = len_inc;
            end
            else if (act.grow_char)
            begin
                if (len_reg == 16'd0)
                    first_next = ch;
                len_next = len_inc;
            end
            else if (act.grow_str)
                len_next = len_inc;
            else
                len_next = len_reg;
        end
    end

    // step record for the queue
    always_comb
    begin
        emit              = 1'b0;
        step              = '0;
        priority if (act.use_flush && fl_emit)
        begin
            emit              = 1'b1;
            step.first        = fl_res;
            step.second       = st_res;
            step.second_valid = act.use_start && st_emit;
        end
        else if (act.use_start)
        begin
            emit       = st_emit;
            step.first = st_res;
        end
        else if (act.op_eq)
        begin
            emit                    = 1'b1;
            step.first.has_token    = 1'b1;
            step.first.token_length = 16'd2;
            unique case (mode_reg)
                MODE_LT: step.first.token_kind = K_LEQ;
                MODE_GT: step.first.token_kind = K_GEQ;
                MODE_EQ: step.first.token_kind = K_EQL;
                default: step.first.token_kind = K_NEQ;
            endcase
        end
        else if (act.lit_bad)
        begin
            emit                  = 1'b1;
            step.first.error_code = ERR_LITERAL;
        end
        else
            emit = 1'b0;
        emit                    = emit && accept;
        step.first.last_result  = !step.second_valid;
        step.second.last_result = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            too_long_reg <= 1'b0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            len_reg      <= '0;
            first_reg    <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            too_long_reg <= too_long_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
            len_reg      <= len_next;
            first_reg    <= first_next;
        end
    end

    // word buffer, no reset: only written entries are compared
    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_reg[buf_wa] <= ch;
    end

endmodule

>>> design/cst_queue.sv
// ----------------------------------------------------------------------------
// cst_queue: step record queue
// short fifo between the scanner and the output stage
// ----------------------------------------------------------------------------
module cst_queue #(
    parameter int DEPTH = cst_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cst_pkg::step_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output cst_pkg::step_t head_data
);
    import cst_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    step_t          mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> design/cst_back.sv
// ----------------------------------------------------------------------------
// cst_back: output stage
// takes one step record at a time and hands out its one or two requests
// ----------------------------------------------------------------------------
module cst_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cst_pkg::step_t   q_data,
    output logic             q_pop,
    output logic             tok_valid,
    input  logic             tok_stall,
    output cst_pkg::tok_req_t tok_req
);
    import cst_pkg::*;

    logic  have_reg, have_next;
    logic  sel_reg, sel_next;
    step_t pair_reg;

    logic taken;
    logic finish;

    assign taken  = have_reg && !tok_stall;
    // last request of the held record leaves this cycle
    assign finish = taken && (sel_reg || !pair_reg.second_valid);
    assign q_pop  = q_valid && (!have_reg || finish);

    assign tok_valid = have_reg;
    assign tok_req   = sel_reg ? pair_reg.second : pair_reg.first;

    always_comb
    begin
        have_next = have_reg;
        sel_next  = sel_reg;
        priority if (q_pop)
        begin
            have_next = 1'b1;
            sel_next  = 1'b0;
        end
        else if (finish)
            have_next = 1'b0;
        else if (taken)
            sel_next = 1'b1;
        else
            have_next = have_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
            sel_reg  <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            pair_reg <= q_data;
    end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the c subset token scanner
// feeds source bytes and end marks through the char channel while a local
// scanner model predicts every token and error request; the tok channel is
// drained under a changing stall pattern and each request is compared with
// the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;

    import cst_pkg::*;

    // scanner built with its default keyword buffer, the model follows it
    localparam int WORD_CHARS   = KEYWORD_BUFFER_CHARS_DEF;
    localparam int RANDOM_CHARS = 820;
    localparam int PAUSE_EVERY  = 250;
    localparam int CYCLE_LIMIT  = 100_000;
    localparam int REPORT_MAX   = 10;

    // kind field of an error-only request
    localparam logic [5:0] NO_KIND = 6'd0;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      char_valid;
    logic      char_stall;
    char_req_t char_req;
    logic      tok_valid;
    logic      tok_stall;
    tok_req_t  tok_req;

    c_subset_token_scanner #(
        .KEYWORD_BUFFER_CHARS(WORD_CHARS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_req   (char_req),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_req    (tok_req)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scanner model state
    // ------------------------------------------------------------------
    // keyword i has token kind i
    string keyword_names [16] = '{
        "for", "while", "do", "if", "else", "switch", "case", "default",
        "int", "char", "const", "printf", "scanf", "void", "main", "return"
    };

    scan_mode_t  sc_mode = MODE_IDLE;
    logic [7:0]  sc_word [WORD_CHARS];
    logic        sc_long = 1'b0;
    logic [30:0] sc_acc = '0;
    logic [15:0] sc_len = '0;
    logic [7:0]  sc_first = '0;
    logic        sc_ovf = 1'b0;

    // requests caused by the byte being scanned
    tok_req_t step_tokens [$];
    // predicted requests, oldest first
    tok_req_t awaited_tokens [$];

    int bad_count   = 0;
    int cycle_count = 0;
    int chars_sent  = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_span  = 0;

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic string show(input tok_req_t t);
        return $sformatf("has=%0d kind=%0d value=%0d length=%0d error=%0d last=%0d",
                         t.has_token, t.token_kind, t.token_value, t.token_length,
                         t.error_code, t.last_result);
    endfunction

    task automatic add_token(input logic has, input logic [5:0] kind,
                             input logic [30:0] value, input logic [15:0] len,
                             input logic [2:0] err);
        step_tokens.push_back('{has_token: has, token_kind: kind, token_value: value,
                                token_length: len, error_code: err, last_result: 1'b0});
    endtask

    // length counts saturate at the top
    task automatic grow_len();
        if (sc_len != LEN_MAX)
            sc_len++;
    endtask

    // only the first buffer-full of a word is kept for keyword matching
    task automatic add_word_char(input logic [7:0] c);
        if (sc_len < WORD_CHARS)
            sc_word[sc_len] = c;
        else
            sc_long = 1'b1;
        grow_len();
    endtask

    function automatic logic [5:0] word_kind();
        string kw;
        logic  hit;
        if (sc_long)
            return K_IDENT;
        for (int i = 0; i < 16; i++)
        begin
            kw = keyword_names[i];
            if (kw.len() == sc_len && kw.len() <= WORD_CHARS)
            begin
                hit = 1'b1;
                for (int j = 0; j < kw.len(); j++)
                    if (sc_word[j] != kw[j])
                        hit = 1'b0;
                if (hit)
                    return 6'(i);
            end
        end
        return K_IDENT;
    endfunction

    // report whatever token is pending and go idle
    task automatic close_token();
        scan_mode_t m;
        m = sc_mode;
        sc_mode = MODE_IDLE;
        case (m)
            MODE_WORD: add_token(1'b1, word_kind(), '0, sc_len, ERR_NONE);
            MODE_NUM:  add_token(1'b1, K_UNSG, sc_acc, sc_len,
                                 sc_ovf ? ERR_OVERFLOW : ERR_NONE);
            MODE_LT:   add_token(1'b1, K_LSS, '0, 16'd1, ERR_NONE);
            MODE_GT:   add_token(1'b1, K_GTR, '0, 16'd1, ERR_NONE);
            MODE_EQ:   add_token(1'b1, K_BECOMES, '0, 16'd1, ERR_NONE);
            MODE_BANG: add_token(1'b0, NO_KIND, '0, '0, ERR_BANG);
            MODE_CHAR: add_token(1'b1, K_CHCON, 31'(sc_first), sc_len, ERR_NONE);
            MODE_STR:  add_token(1'b1, K_STRCON, '0, sc_len, ERR_NONE);
            default:   ;
        endcase
    endtask

    // scan a byte from the idle mode
    task automatic open_token(input logic [7:0] c);
        sc_len = '0;
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
            return;
        if (letter_char(c))
        begin
            sc_mode = MODE_WORD;
            sc_long = 1'b0;
            add_word_char(c);
        end
        else if (c == CH_ZERO)
            add_token(1'b1, K_NUMBER, '0, 16'd1, ERR_NONE);
        else if (digit_char(c))
        begin
            sc_mode = MODE_NUM;
            sc_acc  = 31'(c - CH_ZERO);
            sc_ovf  = 1'b0;
            sc_len  = 16'd1;
        end
        else
        begin
            case (c)
                CH_LT:     sc_mode = MODE_LT;
                CH_GT:     sc_mode = MODE_GT;
                CH_EQ:     sc_mode = MODE_EQ;
                CH_BANG:   sc_mode = MODE_BANG;
                CH_QUOTE:
                begin
                    sc_mode  = MODE_CHAR;
                    sc_first = '0;
                end
                CH_DQUOTE: sc_mode = MODE_STR;
                CH_PLUS:   add_token(1'b1, K_PLUS, '0, 16'd1, ERR_NONE);
                CH_MINUS:  add_token(1'b1, K_MINUS, '0, 16'd1, ERR_NONE);
                CH_STAR:   add_token(1'b1, K_TIMES, '0, 16'd1, ERR_NONE);
                CH_SLASH:  add_token(1'b1, K_DIVID, '0, 16'd1, ERR_NONE);
                CH_LPAR:   add_token(1'b1, K_LPARENT, '0, 16'd1, ERR_NONE);
                CH_RPAR:   add_token(1'b1, K_RPARENT, '0, 16'd1, ERR_NONE);
                CH_LBRK:   add_token(1'b1, K_LBRACK, '0, 16'd1, ERR_NONE);
                CH_RBRK:   add_token(1'b1, K_RBRACK, '0, 16'd1, ERR_NONE);
                CH_LBRC:   add_token(1'b1, K_LBRACE, '0, 16'd1, ERR_NONE);
                CH_RBRC:   add_token(1'b1, K_RBRACE, '0, 16'd1, ERR_NONE);
                CH_COMMA:  add_token(1'b1, K_COMMA, '0, 16'd1, ERR_NONE);
                CH_SEMI:   add_token(1'b1, K_SEMICOLON, '0, 16'd1, ERR_NONE);
                default:   add_token(1'b0, NO_KIND, '0, '0, ERR_UNKNOWN);
            endcase
        end
    endtask

    // advance the model by one accepted request, leaving its output
    // requests in step_tokens
    task automatic scan_char(input char_req_t r);
        logic [7:0] c;
        longint     grown;
        c = r.char_code;
        step_tokens.delete();
        if (r.end_of_input)
            close_token();
        else
        begin
            case (sc_mode)
                MODE_WORD:
                    if (letter_char(c) || digit_char(c))
                        add_word_char(c);
                    else
                    begin
                        close_token();
                        open_token(c);
                    end
                MODE_NUM:
                    if (digit_char(c))
                    begin
                        // saturate and flag, the token keeps going
                        grown = longint'(sc_acc) * 10 + longint'(c - CH_ZERO);
                        if (grown > longint'(VAL_MAX))
                        begin
                            grown  = longint'(VAL_MAX);
                            sc_ovf = 1'b1;
                        end
                        sc_acc = 31'(grown);
                        grow_len();
                    end
                    else
                    begin
                        close_token();
                        open_token(c);
                    end
                MODE_LT, MODE_GT, MODE_EQ, MODE_BANG:
                    if (c == CH_EQ)
                    begin
                        add_token(1'b1, sc_mode == MODE_LT ? K_LEQ :
                                        sc_mode == MODE_GT ? K_GEQ :
                                        sc_mode == MODE_EQ ? K_EQL : K_NEQ,
                                  '0, 16'd2, ERR_NONE);
                        sc_mode = MODE_IDLE;
                    end
                    else
                    begin
                        close_token();
                        open_token(c);
                    end
                MODE_CHAR:
                    if (c == CH_QUOTE)
                        close_token();
                    else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
                             c == CH_SLASH || letter_char(c) || digit_char(c))
                    begin
                        if (sc_len == 0)
                            sc_first = c;
                        grow_len();
                    end
                    else
                        add_token(1'b0, NO_KIND, '0, '0, ERR_LITERAL);
                MODE_STR:
                    if (c == CH_DQUOTE)
                        close_token();
                    else if (c == CH_SPACE || c == CH_BANG || (c >= CH_HASH && c <= CH_TILDE))
                        grow_len();
                    else
                        add_token(1'b0, NO_KIND, '0, '0, ERR_LITERAL);
                default:
                begin
                    sc_mode = MODE_IDLE;
                    open_token(c);
                end
            endcase
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_result = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // char side driver
    // ------------------------------------------------------------------
    function automatic char_req_t byte_req(input logic [7:0] c);
        return '{char_code: c, end_of_input: 1'b0};
    endfunction

    function automatic char_req_t end_req(input logic [7:0] c);
        return '{char_code: c, end_of_input: 1'b1};
    endfunction

    // called right after the clock rises; returns once the request is taken,
    // with valid still high so the next one can follow back to back
    task automatic push_char(input char_req_t r, input bit typed = 1'b0,
                             input tok_req_t want = '0);
        int gap;
        // end of a burst: drop valid for a random gap, then start a new one;
        // now and then a long burst runs with no idle cycle at all
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        char_valid <= 1'b1;
        char_req   <= r;
        do
            @(posedge clk);
        while (char_stall);
        scan_char(r);
        // a directed row with a hand-written result replaces the prediction
        if (typed)
        begin
            want.last_result = 1'b1;
            awaited_tokens.push_back(want);
        end
        else
            foreach (step_tokens[i])
                awaited_tokens.push_back(step_tokens[i]);
        chars_sent++;
    endtask

    // hold off the sender until every predicted request has come back
    task automatic wait_drained();
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_tokens.size() != 0);
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(byte_req(s[i]));
    endtask

    // ------------------------------------------------------------------
    // random source text
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_letter();
        int n;
        n = $urandom_range(0, 52);
        if (n < 26)
            return 8'(8'h61 + n);
        if (n < 52)
            return 8'(8'h41 + n - 26);
        return 8'h5F;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_word_char();
        return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
    endfunction

    // any printable byte a string literal accepts, never the closing quote
    function automatic logic [7:0] rand_str_char();
        int n;
        n = $urandom_range(32, 125);
        return 8'(n >= 34 ? n + 1 : n);
    endfunction

    // bytes a char literal accepts
    function automatic logic [7:0] rand_lit_char();
        case ($urandom_range(0, 9))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4, 5, 6: return rand_letter();
            default: return rand_digit();
        endcase
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    // one token, mostly well formed, sometimes broken or pure noise
    task automatic send_random_token();
        string ops [8] = '{"<", "<=", ">", ">=", "=", "==", "!=", "!"};
        string syms;
        string kw;
        int    pick;
        int    n;
        syms = "+-*/()[]{},;";
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            // keyword, sometimes with a tail that turns it into an identifier
            kw = keyword_names[$urandom_range(0, 15)];
            feed_text(kw);
            if ($urandom_range(0, 4) == 0)
                push_char(byte_req(rand_word_char()));
        end
        else if (pick < 25)
        begin
            // identifier, a fifth of them longer than the keyword buffer
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
            push_char(byte_req(rand_letter()));
            repeat (n - 1) push_char(byte_req(rand_word_char()));
        end
        else if (pick < 37)
        begin
            // number: the top value, one past it, short ones and long ones that may saturate
            case ($urandom_range(0, 9))
                0: feed_text("2147483647");
                1: feed_text("2147483648");
                default:
                begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14)
                                                    : $urandom_range(1, 6);
                    push_char(byte_req(8'(CH_ZERO + $urandom_range(1, 9))));
                    repeat (n - 1) push_char(byte_req(rand_digit()));
                end
            endcase
        end
        else if (pick < 39)
            push_char(byte_req(CH_ZERO));
        else if (pick < 49)
            feed_text(ops[$urandom_range(0, 7)]);
        else if (pick < 60)
            push_char(byte_req(syms[$urandom_range(0, 11)]));
        else if (pick < 70)
        begin
            // char literal, now and then a bad byte inside or no closing quote
            push_char(byte_req(CH_QUOTE));
            n = $urandom_range(0, 3);
            repeat (n)
                push_char(byte_req($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                             : rand_lit_char()));
            if ($urandom_range(0, 6) != 0)
                push_char(byte_req(CH_QUOTE));
        end
        else if (pick < 80)
        begin
            // string literal, same kind of damage
            push_char(byte_req(CH_DQUOTE));
            n = $urandom_range(0, 12);
            repeat (n)
                push_char(byte_req($urandom_range(0, 11) == 0 ? 8'($urandom_range(0, 255))
                                                              : rand_str_char()));
            if ($urandom_range(0, 6) != 0)
                push_char(byte_req(CH_DQUOTE));
        end
        else if (pick < 88)
        begin
            n = $urandom_range(1, 3);
            repeat (n) push_char(byte_req(rand_space()));
        end
        else if (pick < 95)
            push_char(byte_req(8'($urandom_range(0, 255))));
        else
            push_char(end_req(8'($urandom_range(0, 255))));
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    typedef struct {
        char_req_t req;
        bit        typed;
        tok_req_t  want;
    } dir_row_t;

    function automatic dir_row_t plain_row(input char_req_t r);
        return '{req: r, typed: 1'b0, want: '0};
    endfunction

    function automatic dir_row_t typed_row(input char_req_t r, input logic has,
                                           input logic [5:0] kind, input logic [30:0] value,
                                           input logic [15:0] len, input logic [2:0] err);
        return '{req: r, typed: 1'b1,
                 want: '{has_token: has, token_kind: kind, token_value: value,
                         token_length: len, error_code: err, last_result: 1'b1}};
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t rows [$];
        int       start_count;
        int       next_pause;
        rst_n      <= 1'b0;
        char_valid <= 1'b0;
        char_req   <= '0;
        tok_stall  <= 1'b0;
        rows = '{
            // lowest and highest byte start nothing
            typed_row(byte_req(8'h00), 1'b0, NO_KIND, '0, '0, ERR_UNKNOWN),
            typed_row(byte_req(8'hFF), 1'b0, NO_KIND, '0, '0, ERR_UNKNOWN),
            // end mark with nothing pending gives no request
            plain_row(end_req(8'hAA)),
            // a zero is a whole number token at once
            typed_row(byte_req(CH_ZERO), 1'b1, K_NUMBER, '0, 16'd1, ERR_NONE),
            // lone bang
            plain_row(byte_req(CH_BANG)),
            typed_row(byte_req(CH_SPACE), 1'b0, NO_KIND, '0, '0, ERR_BANG),
            // two-character operators and a one-character leftover
            plain_row(byte_req(CH_BANG)),
            typed_row(byte_req(CH_EQ), 1'b1, K_NEQ, '0, 16'd2, ERR_NONE),
            plain_row(byte_req(CH_LT)),
            typed_row(byte_req(CH_EQ), 1'b1, K_LEQ, '0, 16'd2, ERR_NONE),
            plain_row(byte_req(CH_GT)),
            typed_row(byte_req(CH_TAB), 1'b1, K_GTR, '0, 16'd1, ERR_NONE),
            plain_row(byte_req(CH_EQ)),
            typed_row(byte_req(CH_EQ), 1'b1, K_EQL, '0, 16'd2, ERR_NONE),
            // empty char literal
            plain_row(byte_req(CH_QUOTE)),
            typed_row(byte_req(CH_QUOTE), 1'b1, K_CHCON, '0, '0, ERR_NONE),
            // bad byte inside a char literal is dropped
            plain_row(byte_req(CH_QUOTE)),
            typed_row(byte_req(8'h80), 1'b0, NO_KIND, '0, '0, ERR_LITERAL),
            plain_row(byte_req("z")),
            typed_row(byte_req(CH_QUOTE), 1'b1, K_CHCON, 31'h7A, 16'd1, ERR_NONE),
            // string cut short by the end mark after a bad byte
            plain_row(byte_req(CH_DQUOTE)),
            typed_row(byte_req(CH_NL), 1'b0, NO_KIND, '0, '0, ERR_LITERAL),
            typed_row(end_req(8'h55), 1'b1, K_STRCON, '0, '0, ERR_NONE),
            typed_row(byte_req(CH_SEMI), 1'b1, K_SEMICOLON, '0, 16'd1, ERR_NONE),
            // a byte that closes one token and opens another
            plain_row(byte_req(CH_NINE)),
            plain_row(byte_req(CH_GT)),
            typed_row(end_req(8'h00), 1'b1, K_GTR, '0, 16'd1, ERR_NONE)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            push_char(rows[i].req, rows[i].typed, rows[i].want);
        wait_drained();

        // random source text, with a full drain every few hundred bytes
        start_count = chars_sent;
        next_pause  = chars_sent + PAUSE_EVERY;
        while (chars_sent - start_count < RANDOM_CHARS)
        begin
            send_random_token();
            if ($urandom_range(0, 1) == 0)
                push_char(byte_req(rand_space()));
            if (chars_sent >= next_pause)
            begin
                wait_drained();
                next_pause = chars_sent + PAUSE_EVERY;
            end
        end
        push_char(end_req(8'($urandom_range(0, 255))));

        wait_drained();
        // keep clocking a little longer to catch any stray request
        repeat (8) @(posedge clk);
        if (bad_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // tok side: check each taken request, then pick the next stall value
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : tok_sink
        tok_req_t want;
        if (rst_n && tok_valid && !tok_stall)
        begin
            if (awaited_tokens.size() == 0)
            begin
                bad_count++;
                if (bad_count <= REPORT_MAX)
                    $display("unexpected token request: %s", show(tok_req));
            end
            else
            begin
                want = awaited_tokens.pop_front();
                if (tok_req.has_token !== want.has_token ||
                    tok_req.token_kind !== want.token_kind ||
                    tok_req.token_value !== want.token_value ||
                    tok_req.token_length !== want.token_length ||
                    tok_req.error_code !== want.error_code ||
                    tok_req.last_result !== want.last_result)
                begin
                    bad_count++;
                    if (bad_count <= REPORT_MAX)
                        $display("token mismatch: expected %s, got %s",
                                 show(want), show(tok_req));
                end
            end
        end

        // stall pattern switches between no stall, light random, a fixed
        // rhythm and heavy random, each held for a random span
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(40, 300);
        end
        stall_span--;
        case (stall_mode)
            0:       tok_stall <= 1'b0;
            1:       tok_stall <= ($urandom_range(0, 99) < 30);
            2:       tok_stall <= ((stall_span % 9) < 4);
            default: tok_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    // ------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------
    always @(posedge clk)
        cycle_count++;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

endmodule
